// ===== design/vertex_weld_hash_table_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef VERTEX_WELD_HASH_TABLE_TOP_ASSERT_SVH
`define VERTEX_WELD_HASH_TABLE_TOP_ASSERT_SVH
`define VW_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/vwht_pkg.sv =====
package vwht_pkg;
    localparam int unsigned TableEntries = 1024;
    localparam int unsigned IndexBits    = 20;
    localparam logic [31:0] HashMix  = 32'h045d9f3b;
    localparam logic [31:0] HashMul  = 32'd1000003;
    localparam logic [31:0] HashSeed = 32'h00345678;
    localparam logic [31:0] HashTail = 32'd6;
    localparam logic [31:0] HashAll  = 32'hFFFFFFFF;
    localparam logic [31:0] HashSub  = 32'hFFFFFFFE;
    localparam logic        KindLookup = 1'b0;
    localparam logic        KindClear  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_HASH, ST_READ, ST_WAIT, ST_CHECK, ST_OUT
    } vwht_state_t;

    typedef struct packed {
        logic load;
        logic hash_start;
        logic clr_start;
        logic clr_step;
        logic rd;
        logic probe_next;
        logic do_insert;
        logic set_dup;
        logic set_full;
        logic set_clear;
    } vwht_cmd_t;

    typedef struct packed {
        logic hash_done;
        logic clr_last;
        logic slot_empty;
        logic key_match;
        logic probe_last;
        logic is_clear;
    } vwht_stat_t;
endpackage

// ===== design/vertex_weld_hash_table_top.sv =====
// A lookup is accepted, hashed, then the first probed slot is read and checked; every further
// probed slot repeats the read and the check, one slot after another (linear probing).
// One transaction at a time: a new one is accepted only once the last result has been taken.
// The hash works through six words, three phases each; the table's one read port sets probe cost.
// Reset (aresetn low, synchronous) starts a clearing pass over every table entry.
// A clear transaction sweeps the valid bits, then presents its result with all flags low.
module vertex_weld_hash_table_top
    import vwht_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntries,
    parameter int unsigned INDEX_BITS    = IndexBits
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((INDEX_BITS+96+7)/8)*8-1:0] s_tdata, // vertex_index, coord_x, coord_y, coord_z
    input  logic                  s_tuser,  // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((INDEX_BITS+7)/8)*8-1:0] m_tdata,  // welded_index
    output logic [1:0]            m_tuser   // was_duplicate, table_full
);
    localparam int unsigned OW = ((INDEX_BITS+7)/8)*8;
    vwht_cmd_t             cmd;
    vwht_stat_t            stat;
    logic [INDEX_BITS-1:0] oidx;
    logic                  dup, full;

    vwht_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .stat(stat), .cmd(cmd)
    );

    vwht_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .INDEX_BITS(INDEX_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_kind(s_tuser), .in_index(s_tdata[INDEX_BITS-1:0]),
        .in_x(s_tdata[INDEX_BITS +: 32]), .in_y(s_tdata[INDEX_BITS+32 +: 32]),
        .in_z(s_tdata[INDEX_BITS+64 +: 32]),
        .out_index(oidx), .out_dup(dup), .out_full(full)
    );

    assign m_tdata = OW'(oidx);
    assign m_tuser = {full, dup};
endmodule

// ===== design/vwht_ram.sv =====
module vwht_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/vwht_hash.sv =====
module vwht_hash
    import vwht_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] x,
    input  logic [31:0] y,
    input  logic [31:0] z,
    output logic        done,
    output logic [31:0] hash
);
    // Three phases per word over six words: two mix multiplies, with the fold multiply in the
    // second phase. The done pulse follows the last fold, once the hash register holds the result.
    logic [2:0]  word_reg, word_next;
    logic [1:0]  ph_reg, ph_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] w_reg, w_next, v_reg, v_next;
    logic [31:0] cur, prod_in, prod;

    always_comb begin
        case (word_reg)
            3'd0: cur = x;
            3'd1: cur = {32{x[31]}};
            3'd2: cur = y;
            3'd3: cur = {32{y[31]}};
            3'd4: cur = z;
            default: cur = {32{z[31]}};
        endcase
    end

    assign prod_in = (ph_reg == 2'd0) ? (cur ^ (cur >> 16)) : (w_reg ^ (w_reg >> 16));
    assign prod    = prod_in * HashMix;

    always_comb begin
        word_next = word_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        w_next    = w_reg;
        v_next    = v_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            word_next = '0;
            ph_next   = '0;
            v_next    = HashSeed;
        end else if (busy_reg) begin
            case (ph_reg)
                2'd0: begin
                    w_next  = prod;
                    ph_next = 2'd1;
                end
                2'd1: begin
                    w_next  = prod;
                    v_next  = v_reg * HashMul;
                    ph_next = 2'd2;
                end
                default: begin
                    v_next  = v_reg ^ w_reg ^ (w_reg >> 16);
                    ph_next = 2'd0;
                    if (word_reg == 3'd5) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        word_next = word_reg + 3'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        word_reg <= word_next;
        ph_reg   <= ph_next;
        w_reg    <= w_next;
        v_reg    <= v_next;
    end

    assign done = done_reg;

    always_comb begin
        hash = v_reg ^ HashTail;
        if (hash == HashAll) begin
            hash = HashSub;
        end
    end
endmodule

// ===== design/vwht_datapath.sv =====
module vwht_datapath
    import vwht_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntries,
    parameter int unsigned INDEX_BITS    = IndexBits
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vwht_cmd_t             cmd,
    output vwht_stat_t            stat,
    input  logic                  in_kind,
    input  logic [INDEX_BITS-1:0] in_index,
    input  logic [31:0]           in_x,
    input  logic [31:0]           in_y,
    input  logic [31:0]           in_z,
    output logic [INDEX_BITS-1:0] out_index,
    output logic                  out_dup,
    output logic                  out_full
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned EW = 96 + INDEX_BITS;

    logic                  kind_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [31:0]           x_reg, y_reg, z_reg;
    logic [AW-1:0]         slot_reg, slot_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0] oidx_reg;
    logic                  dup_reg, full_reg;
    logic                  hdone;
    logic [31:0]           hash;
    logic [EW-1:0]         rdata;
    logic                  vrd;
    logic                  vwe;
    logic [AW-1:0]         vwaddr;

    vwht_hash u_hash (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.hash_start),
        .x(x_reg), .y(y_reg), .z(z_reg), .done(hdone), .hash(hash)
    );

    vwht_ram #(.Width(EW), .Depth(TABLE_ENTRIES)) u_entry (
        .aclk(aclk), .we(cmd.do_insert), .waddr(slot_reg),
        .wdata({idx_reg, z_reg, y_reg, x_reg}), .raddr(slot_reg), .rdata(rdata)
    );

    assign vwe    = cmd.do_insert || cmd.clr_step;
    assign vwaddr = cmd.clr_step ? cnt_reg : slot_reg;
    vwht_ram #(.Width(1), .Depth(TABLE_ENTRIES)) u_valid (
        .aclk(aclk), .we(vwe), .waddr(vwaddr), .wdata(cmd.do_insert),
        .raddr(slot_reg), .rdata(vrd)
    );

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (cmd.clr_start) begin
            cnt_next = '0;
        end else if (cmd.clr_step) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (hdone) begin
            slot_next = hash[AW-1:0];
            cnt_next  = '0;
        end else if (cmd.probe_next) begin
            slot_next = slot_reg + 1'b1;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KindLookup;
            cnt_reg  <= '0;
        end else begin
            if (cmd.load) begin
                kind_reg <= in_kind;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg  <= in_index;
            x_reg    <= in_x;
            y_reg    <= in_y;
            z_reg    <= in_z;
        end
        slot_reg <= slot_next;
        if (cmd.do_insert || cmd.set_full) begin
            oidx_reg <= idx_reg;
            dup_reg  <= 1'b0;
            full_reg <= cmd.set_full;
        end else if (cmd.set_dup) begin
            oidx_reg <= rdata[EW-1:96];
            dup_reg  <= 1'b1;
            full_reg <= 1'b0;
        end else if (cmd.set_clear) begin
            oidx_reg <= '0;
            dup_reg  <= 1'b0;
            full_reg <= 1'b0;
        end
    end

    assign stat.hash_done  = hdone;
    assign stat.clr_last   = (cnt_reg == {AW{1'b1}});
    assign stat.slot_empty = !vrd;
    assign stat.key_match  = (rdata[95:0] == {z_reg, y_reg, x_reg});
    assign stat.probe_last = (cnt_reg == {AW{1'b1}});
    assign stat.is_clear   = (kind_reg == KindClear);
    assign out_index = oidx_reg;
    assign out_dup   = dup_reg;
    assign out_full  = full_reg;
endmodule

// ===== design/vwht_ctrl.sv =====
module vwht_ctrl
    import vwht_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  vwht_stat_t stat,
    output vwht_cmd_t  cmd
);
    vwht_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (stat.is_clear) begin
                    cmd.clr_start = 1'b1;
                    cmd.set_clear = 1'b1;
                    state_next    = ST_CLEAR;
                end else begin
                    cmd.hash_start = 1'b1;
                    state_next     = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (stat.hash_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.slot_empty) begin
                    cmd.do_insert = 1'b1;
                    state_next    = ST_OUT;
                end else if (stat.key_match) begin
                    cmd.set_dup = 1'b1;
                    state_next  = ST_OUT;
                end else if (stat.probe_last) begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = stat.is_clear ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== design/vwht_checker.sv =====
`include "vertex_weld_hash_table_top_assert.svh"
module vwht_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [1:0] m_tuser
);
    `VW_ASSERT_IMPL(a_flags_excl, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    `VW_ASSERT_IMPL(a_no_ready_busy, aclk, aresetn, m_tvalid, !s_tready)
    `VW_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `VW_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tuser))
endmodule

bind vertex_weld_hash_table_top vwht_checker u_vwht_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser)
);
